@@ sv/fult_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fult_pkg
// Shared types and constants of the first unique letter tracker.
// ----------------------------------------------------------------------------
package fult_pkg;

    // letter index width on the ports
    localparam int LETTER_W  = 5;
    // default alphabet size
    localparam int ALPHA_DEF = 26;
    // occurrence count width and codes
    localparam int CNT_W = 2;
    localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_SAT  = 2'd2;

    // input word
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                start_new;
    } t_in;

    // result word
    typedef struct packed {
        logic [LETTER_W-1:0] first_unique;
        logic                none_unique;
    } t_out;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_QWAIT,
        S_CHK,
        S_RES
    } t_state;

endpackage

@@ sv/fult_cnt_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fult_cnt_store
// Per-letter occurrence count memory with one valid bit per entry; a clear
// drops all valid bits at once so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module fult_cnt_store
    import fult_pkg::*;
#(
    parameter int DEPTH = ALPHA_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [CNT_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [CNT_W-1:0] i_wr_data
);

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [CNT_W-1:0] r_q;
    logic             r_q_ok;

    // storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q    <= r_mem[i_rd_addr];
            r_q_ok <= r_valid[i_rd_addr] & ~i_clear;
        end
    end

    // valid bits, cleared by reset or a new string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_q_ok ? r_q : CNT_ZERO;

endmodule

@@ sv/fult_queue_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fult_queue_ram
// Arrival-order ring of unique letters, one write and one registered read.
// ----------------------------------------------------------------------------
module fult_queue_ram
    import fult_pkg::*;
#(
    parameter int DEPTH = ALPHA_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [LETTER_W-1:0] i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [LETTER_W-1:0] o_rd_data
);

    logic [LETTER_W-1:0] r_mem [DEPTH];
    logic [LETTER_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

@@ sv/first_unique_letter_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_unique_letter_tracker_unit
// Reports, for each incoming letter, the oldest letter of the current string
// that has been seen exactly once.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one word per letter,
// alphabet index plus a start flag that clears the string before the letter.
// Output channel (o_out_valid / i_out_ready / o_out_data): one word per input
// word, the oldest unique letter or none_unique set.
// Sequence: when no queue head is retired, the word passes through S_UPD (count
// read result) and loads the output register once it is free; each retired head
// that leaves the queue non-empty adds S_QWAIT (queue read), then S_CHK (count
// read of the new head). Retirements are at most one per earlier push.
// A new word is accepted only in S_IDLE, after the last word has finished.
// The sequencer handles one word at a time; the count memory and the queue
// memory, each with a single registered read port, set this order of steps.
// Reset clears the counts (valid bits), queue pointers and fill, and the
// output valid. A stalled receiver holds the result in the output
// register; the next word is still accepted and its result waits in the
// sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module first_unique_letter_tracker_unit
    import fult_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHA_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int IW = $clog2(ALPHABET_SIZE);
    localparam int FW = $clog2(ALPHABET_SIZE + 1);
    localparam int EW = (IW > LETTER_W) ? IW : LETTER_W;

    // wrap a queue pointer at the alphabet size
    function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
        ptr_inc = (p == IW'(ALPHABET_SIZE - 1)) ? '0 : IW'(p + IW'(1));
    endfunction

    t_state              r_state, n_state;
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_tail, n_tail;
    logic [FW-1:0]       r_fill, n_fill;
    logic [LETTER_W-1:0] r_head_let, n_head_let;
    logic [LETTER_W-1:0] r_letter, n_letter;
    logic                r_inr, n_inr;
    logic                r_ovalid;
    t_out                r_odata;

    logic                in_acc;
    logic [EW-1:0]       in_ext;
    logic [EW-1:0]       q_ext;
    logic [EW-1:0]       let_ext;
    logic [IW-1:0]       let_idx;
    logic                out_free;
    logic                go_qwait;
    logic                finish;
    logic                do_inc;
    logic                push;
    logic                res_none;
    t_out                res;

    logic                cnt_clear;
    logic                cnt_rd_en;
    logic [IW-1:0]       cnt_rd_addr;
    logic [CNT_W-1:0]    cnt_rd_data;
    logic                cnt_wr_en;
    logic [CNT_W-1:0]    cnt_wr_data;
    logic                q_wr_en;
    logic                q_rd_en;
    logic [LETTER_W-1:0] q_rd_data;

    fult_cnt_store #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (IW)
    ) u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cnt_clear),
        .i_rd_en   (cnt_rd_en),
        .i_rd_addr (cnt_rd_addr),
        .o_rd_data (cnt_rd_data),
        .i_wr_en   (cnt_wr_en),
        .i_wr_addr (let_idx),
        .i_wr_data (cnt_wr_data)
    );

    fult_queue_ram #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (IW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (r_letter),
        .i_rd_en   (q_rd_en),
        .i_rd_addr (n_head),
        .o_rd_data (q_rd_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_ovalid || i_out_ready;
    assign in_ext     = EW'(i_in_data.letter);
    assign q_ext      = EW'(q_rd_data);
    assign let_ext    = EW'(r_letter);
    assign let_idx    = (int'(r_letter) < ALPHABET_SIZE) ? let_ext[IW-1:0] : '0;

    // datapath: count update, push, head retirement and result
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_head_let  = r_head_let;
        n_letter    = r_letter;
        n_inr       = r_inr;
        cnt_clear   = 1'b0;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = in_ext[IW-1:0];
        cnt_wr_en   = 1'b0;
        cnt_wr_data = CNT_W'(cnt_rd_data + CNT_ONE);
        q_wr_en     = 1'b0;
        q_rd_en     = 1'b0;
        go_qwait    = 1'b0;
        finish      = 1'b0;
        do_inc      = 1'b0;
        push        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    cnt_rd_en = 1'b1;
                    n_letter  = i_in_data.letter;
                    n_inr     = int'(i_in_data.letter) < ALPHABET_SIZE;
                    if (i_in_data.start_new) begin
                        cnt_clear = 1'b1;
                        n_head    = '0;
                        n_tail    = '0;
                        n_fill    = '0;
                    end
                end
            end
            S_UPD: begin
                do_inc    = r_inr && (cnt_rd_data < CNT_SAT);
                push      = do_inc && (cnt_rd_data == CNT_ZERO)
                            && (r_fill < FW'(ALPHABET_SIZE));
                cnt_wr_en = do_inc;
                q_wr_en   = push;
                if (push) begin
                    n_tail = ptr_inc(r_tail);
                    n_fill = FW'(r_fill + FW'(1));
                    if (r_fill == '0) begin
                        n_head_let = r_letter;
                    end
                end
                // head letter turned repeated: retire it
                if (r_inr && (r_fill != '0) && (cnt_rd_data == CNT_ONE)
                    && (r_letter == r_head_let)) begin
                    n_head = ptr_inc(r_head);
                    n_fill = FW'(r_fill - FW'(1));
                    if (n_fill != '0) begin
                        q_rd_en  = 1'b1;
                        go_qwait = 1'b1;
                    end else begin
                        finish = 1'b1;
                    end
                end else begin
                    finish = 1'b1;
                end
            end
            S_QWAIT: begin
                // new head letter known, fetch its count
                n_head_let  = q_rd_data;
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = q_ext[IW-1:0];
            end
            S_CHK: begin
                if (cnt_rd_data == CNT_ONE) begin
                    finish = 1'b1;
                end else begin
                    n_head = ptr_inc(r_head);
                    n_fill = FW'(r_fill - FW'(1));
                    if (n_fill != '0) begin
                        q_rd_en  = 1'b1;
                        go_qwait = 1'b1;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            S_RES: begin
                finish = 1'b1;
            end
            default: begin
                finish = 1'b0;
            end
        endcase
        res_none         = (n_fill == '0);
        res.none_unique  = res_none;
        res.first_unique = res_none ? '0 : n_head_let;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_UPD;
                end
            end
            S_QWAIT: begin
                n_state = S_CHK;
            end
            S_UPD, S_CHK, S_RES: begin
                if (go_qwait) begin
                    n_state = S_QWAIT;
                end else if (finish) begin
                    n_state = out_free ? S_IDLE : S_RES;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            if (finish && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_head_let <= n_head_let;
        r_letter   <= n_letter;
        r_inr      <= n_inr;
        if (finish && out_free) begin
            r_odata <= res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
